### hw/rtl/srg_pkg.sv
// Package for the stepper ramp generator: widths, codes, FSM states and
// the request/response structs of the serial divider. No dependencies.
package srg_pkg;

  localparam int unsigned COUNT_BITS    = 24;
  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned DIV_BITS      = 16;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
  localparam int unsigned CFG_IDX_BITS  = 3;

  localparam logic [15:0] PERIOD_TOP = 16'hFFFE;
  localparam logic [15:0] DIV_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_PERIOD = 3'd0,
    CFG_MIN_PERIOD   = 3'd1,
    CFG_PERIOD_FLOOR = 3'd2,
    CFG_ACCEL_DIV    = 3'd3,
    CFG_DIR_POLARITY = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN_DIV,
    ST_PLAN_STEP,
    ST_TICK_DIV,
    ST_TICK_STEP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/srg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on srg_pkg.
module srg_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srg_pkg::div_req_t req_i,
  output srg_pkg::div_rsp_t rsp_o
);
  import srg_pkg::*;

  logic [DIV_BITS-1:0]     rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic [DIV_BITS:0]       trial;

  assign trial = {rem_q, quo_q[DIV_BITS-1]} - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = DIV_CNT_BITS'(DIV_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DIV_BITS]) begin
        rem_d = trial[DIV_BITS-1:0];
      end else begin
        rem_d = {rem_q[DIV_BITS-2:0], quo_q[DIV_BITS-1]};
      end
      quo_d = {quo_q[DIV_BITS-2:0], ~trial[DIV_BITS]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hw/rtl/stepper_ramp_generator.sv
// Stepper ramp generator top level: control FSM, motion state, config
// registers and output register. Depends on srg_pkg and srg_div.
//
// Usage: one input transaction (mode, step_count, reverse, hold) yields
// exactly one output transaction (period, position, step_dir, running,
// done_res). Configuration writes arrive on the cfg channel, which is
// always ready; write only while the block is idle.
// Stop and unused modes go straight to the output register; a tick runs
// one serial division of the period by the ramp divisor; a start move
// runs one planning division after another until the period reaches
// min_period, so the plan's length is set by start_period, min_period
// and accel_divisor.
// One item is processed at a time; in_ready_o is high only when idle.
// The output register holds a result until taken; the next item may be
// accepted meanwhile, and its result waits in the final state while the
// receiver stalls.
// Reset clears most motion state (stopped, position 0) and loads default
// configuration: start 20000, min 1000, floor 100, divisor 100, polarity 0.
module stepper_ramp_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic [23:0]                      step_count_i,
  input  logic                             reverse_i,
  input  logic                             hold_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [15:0]                      period_o,
  output logic signed [31:0]               position_o,
  output logic                             step_dir_o,
  output logic                             running_o,
  output logic                             done_res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [srg_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);
  import srg_pkg::*;

  state_e state_q, state_d;

  logic [15:0] start_q, min_q, floor_q;
  logic [7:0]  acc_q;
  logic        pol_q;

  logic [15:0]              cur_q, cur_d, rdiv_q, rdiv_d, pp_q, pp_d, pdiv_q, pdiv_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [COUNT_BITS-1:0]    steps_q, steps_d, accel_q, accel_d, n_q, n_d;
  logic                     run_q, run_d, dir_q, dir_d, done_q, done_d, hold_q, hold_d;

  logic        ov_q, ov_d;
  logic [15:0] o_period_q, o_period_d;
  logic [31:0] o_pos_q, o_pos_d;
  logic        o_dir_q, o_dir_d, o_run_q, o_run_d, o_done_q, o_done_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0]           q, acc_div, rdiv1, cur_t, rdiv_t;
  logic [16:0]           floor_sum, min_sum, up_sum;
  logic                  in_acc, slow_end;
  logic [COUNT_BITS-1:0] cnt_in;

  srg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cnt_in      = COUNT_BITS'(step_count_i);
  assign acc_div     = (acc_q == 8'd0) ? 16'd1 : {8'd0, acc_q};
  assign rdiv1       = (rdiv_q == 16'd0) ? 16'd1 : rdiv_q;
  assign q           = div_rsp.quotient;
  assign floor_sum   = {1'b0, floor_q} + {1'b0, q};
  assign min_sum     = {1'b0, min_q} + {1'b0, q};
  assign up_sum      = {1'b0, cur_q} + {1'b0, q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'd20000;
      min_q   <= 16'd1000;
      floor_q <= 16'd100;
      acc_q   <= 8'd100;
      pol_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_PERIOD: start_q <= cfg_data_i;
        CFG_MIN_PERIOD:   min_q   <= cfg_data_i;
        CFG_PERIOD_FLOOR: floor_q <= cfg_data_i;
        CFG_ACCEL_DIV:    acc_q   <= cfg_data_i[7:0];
        CFG_DIR_POLARITY: pol_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    rdiv_d     = rdiv_q;
    pp_d       = pp_q;
    pdiv_d     = pdiv_q;
    pos_d      = pos_q;
    steps_d    = steps_q;
    accel_d    = accel_q;
    n_d        = n_q;
    run_d      = run_q;
    dir_d      = dir_q;
    done_d     = done_q;
    hold_d     = hold_q;
    ov_d       = ov_q && !out_ready_i;
    o_period_d = o_period_q;
    o_pos_d    = o_pos_q;
    o_dir_d    = o_dir_q;
    o_run_d    = o_run_q;
    o_done_d   = o_done_q;
    div_req    = '0;
    cur_t      = cur_q;
    rdiv_t     = rdiv_q;
    slow_end   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          done_d  = 1'b0;
          hold_d  = hold_i;
          state_d = ST_FIN;
          case (mode_i)
            MODE_START: begin
              if (!run_q) begin
                cur_d   = start_q;
                rdiv_d  = acc_div;
                dir_d   = pol_q ^ reverse_i;
                steps_d = cnt_in;
                accel_d = '0;
                run_d   = 1'b1;
                if (cnt_in != '0) begin
                  pp_d             = start_q;
                  pdiv_d           = acc_div;
                  n_d              = '0;
                  div_req.start    = 1'b1;
                  div_req.dividend = start_q;
                  div_req.divisor  = acc_div;
                  state_d          = ST_PLAN_DIV;
                end
              end
            end
            MODE_TICK: begin
              if (run_q) begin
                div_req.start    = 1'b1;
                div_req.dividend = cur_q;
                div_req.divisor  = rdiv1;
                state_d          = ST_TICK_DIV;
              end
            end
            MODE_STOP: begin
              if (run_q) begin
                run_d   = 1'b0;
                cur_d   = '0;
                steps_d = '0;
                accel_d = '0;
                done_d  = 1'b1;
              end else begin
                pos_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PLAN_DIV: begin
        if (div_rsp.done) state_d = ST_PLAN_STEP;
      end
      ST_PLAN_STEP: begin
        if (q == 16'd0 || {1'b0, pp_q} <= min_sum) begin
          if ({n_q, 1'b0} > {1'b0, steps_q}) begin
            accel_d = steps_q >> 1;
          end else begin
            accel_d = steps_q - n_q;
          end
          state_d = ST_FIN;
        end else begin
          pp_d = pp_q - q;
          if (pdiv_q != DIV_MAX) pdiv_d = pdiv_q + 16'd1;
          if (n_q != '1) n_d = n_q + 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = pp_q - q;
          div_req.divisor  = (pdiv_q != DIV_MAX) ? pdiv_q + 16'd1 : pdiv_q;
          state_d          = ST_PLAN_DIV;
        end
      end
      ST_TICK_DIV: begin
        if (div_rsp.done) state_d = ST_TICK_STEP;
      end
      ST_TICK_STEP: begin
        if (dir_q) pos_d = pos_q - 1'b1;
        else       pos_d = pos_q + 1'b1;
        if ((steps_q == '0) ? hold_q : (accel_q != '0)) begin
          if (cur_q > min_q && {1'b0, cur_q} > floor_sum) begin
            cur_t = cur_q - q;
            if (rdiv_q != DIV_MAX) rdiv_t = rdiv_q + 16'd1;
          end
        end else if (steps_q == '0 || cur_q <= PERIOD_TOP) begin
          if (up_sum < {1'b0, start_q}) begin
            cur_t = up_sum[15:0];
            if (rdiv_q > 16'd1) rdiv_t = rdiv_q - 16'd1;
          end else begin
            slow_end = 1'b1;
          end
        end
        cur_d  = cur_t;
        rdiv_d = rdiv_t;
        if (steps_q == '0) begin
          if (!hold_q && slow_end) begin
            run_d  = 1'b0;
            cur_d  = '0;
            done_d = 1'b1;
          end
        end else begin
          if (accel_q != '0) accel_d = accel_q - 1'b1;
          steps_d = steps_q - 1'b1;
          if (steps_q == COUNT_BITS'(1)) begin
            run_d   = 1'b0;
            cur_d   = '0;
            accel_d = '0;
            done_d  = 1'b1;
          end
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d       = 1'b1;
          o_period_d = cur_q;
          o_pos_d    = 32'($signed(pos_q));
          o_dir_d    = dir_q;
          o_run_d    = run_q;
          o_done_d   = done_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      rdiv_q  <= '0;
      pos_q   <= '0;
      steps_q <= '0;
      accel_q <= '0;
      run_q   <= 1'b0;
      dir_q   <= 1'b0;
      pp_q    <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      rdiv_q  <= rdiv_d;
      pos_q   <= pos_d;
      steps_q <= steps_d;
      accel_q <= accel_d;
      run_q   <= run_d;
      dir_q   <= dir_d;
      pp_q    <= pp_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pdiv_q     <= pdiv_d;
    done_q     <= done_d;
    hold_q     <= hold_d;
    o_period_q <= o_period_d;
    o_pos_q    <= o_pos_d;
    o_dir_q    <= o_dir_d;
    o_run_q    <= o_run_d;
    o_done_q   <= o_done_d;
  end

  assign out_valid_o = ov_q;
  assign period_o    = o_period_q;
  assign position_o  = o_pos_q;
  assign step_dir_o  = o_dir_q;
  assign running_o   = o_run_q;
  assign done_res_o  = o_done_q;

endmodule

### hw/rtl/srg_chk.sv
// Port-level checker for the stepper ramp generator, bound to the top.
// Depends on stepper_ramp_generator ports only.
module srg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] period_o,
  input logic        running_o,
  input logic        done_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !running_o)
    else $error("done reported while still running");

  a_idle_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> period_o == 16'd0)
    else $error("nonzero period while stopped");

endmodule

bind stepper_ramp_generator srg_chk u_srg_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .period_o   (period_o),
  .running_o  (running_o),
  .done_res_o (done_res_o)
);
